@@ rtl/core/bmhq_pkg.sv @@
`default_nettype none
package bmhq_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = 6;
    localparam int COUNT_W  = 7;

    localparam logic [1:0] ACT_INSERT  = 2'd0;
    localparam logic [1:0] ACT_EXTRACT = 2'd1;
    localparam logic [1:0] ACT_SEARCH  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
    } bmhq_in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               found;
        logic [5:0]         found_index;
        logic [1:0]         status;
        logic [6:0]         entry_count;
    } bmhq_out_t;

    // controller -> datapath: one micro-operation per cycle
    typedef logic [3:0] bmhq_cmd_t;

    localparam bmhq_cmd_t CMD_NOP        = 4'd0;   // hold, read at node
    localparam bmhq_cmd_t CMD_LOAD       = 4'd1;   // capture input word
    localparam bmhq_cmd_t CMD_LOAD_INS   = 4'd2;   // capture and open a slot at the end
    localparam bmhq_cmd_t CMD_LOAD_FULL  = 4'd3;   // capture and flag a full heap
    localparam bmhq_cmd_t CMD_LOAD_EMPTY = 4'd4;   // capture and flag an empty heap
    localparam bmhq_cmd_t CMD_UP_RD      = 4'd5;   // read the parent
    localparam bmhq_cmd_t CMD_PLACE      = 4'd6;   // write the held value at node
    localparam bmhq_cmd_t CMD_UP_MOVE    = 4'd7;   // move parent down, climb
    localparam bmhq_cmd_t CMD_EX_RD      = 4'd8;   // read root and last, shrink
    localparam bmhq_cmd_t CMD_EX_MV      = 4'd9;   // take root, hold last
    localparam bmhq_cmd_t CMD_DN_RD      = 4'd10;  // read both children
    localparam bmhq_cmd_t CMD_DN_CMP     = 4'd11;  // pick the larger child
    localparam bmhq_cmd_t CMD_DN_MOVE    = 4'd12;  // pull child up, descend
    localparam bmhq_cmd_t CMD_SR_HIT     = 4'd13;  // mark the match
    localparam bmhq_cmd_t CMD_SR_NEXT    = 4'd14;  // advance the scan
    localparam bmhq_cmd_t CMD_SR_MISS    = 4'd15;  // end the scan without a match

    // datapath -> controller
    typedef struct packed {
        logic full;        // no room for an insert
        logic empty;       // nothing to extract
        logic at_root;     // sift-up reached the root
        logic up_greater;  // held value beats the parent
        logic scan_end;    // scan ran past the last entry
        logic scan_hit;    // scanned entry matches
        logic at_best;     // node not smaller than either child
    } bmhq_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/binary_max_heap_queue_unit.sv @@
// The time from the accepting edge to the result strobe depends on the action:
// insert on how far the value climbs, extract on the levels visited by the
// sift-down, search on the entries scanned, a hit ending the scan early.
// One word at a time: busy holds through the strobe, so the next word is
// accepted in the cycle after it. The strobe lasts one cycle; the receiver cannot stall.
// Reset (async, rst_n low) empties the heap; memory contents are not cleared.
`default_nettype none
module binary_max_heap_queue_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire bmhq_pkg::bmhq_in_t in_word,
    output logic                    busy,
    output logic                    done,
    output bmhq_pkg::bmhq_out_t     out_word
);
    import bmhq_pkg::*;

    bmhq_cmd_t  cmd;
    bmhq_stat_t stat;

    bmhq_controller u_ctrl (
        .clk, .rst_n, .start, .action (in_word.action), .stat,
        .busy, .done, .cmd
    );

    bmhq_datapath u_dp (
        .clk, .rst_n, .cmd, .in_value (in_word.value), .done,
        .stat, .out_word
    );

endmodule
`default_nettype wire

@@ rtl/core/bmhq_datapath.sv @@
`default_nettype none
module bmhq_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bmhq_pkg::bmhq_cmd_t  cmd,
    input  wire logic signed [31:0]   in_value,
    input  wire logic                 done,
    output bmhq_pkg::bmhq_stat_t      stat,
    output bmhq_pkg::bmhq_out_t       out_word
);
    import bmhq_pkg::*;

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rdata_a, rdata_b;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr, raddr_a, raddr_b;
    logic signed [31:0] mem_wdata;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] node_reg, node_next;
    logic [COUNT_W-1:0] best_reg, best_next;
    logic signed [31:0] val_reg, val_next;      // value being sifted / searched
    logic signed [31:0] res_reg, res_next;
    logic signed [31:0] bestv_reg, bestv_next;
    logic               found_reg, found_next;
    logic [1:0]         status_reg, status_next;

    logic [COUNT_W-1:0] parent, left, right;
    logic               left_ok, right_ok;
    logic [5:0]         idx_out;

    assign parent   = (node_reg - 7'd1) >> 1;
    assign left     = {node_reg[COUNT_W-2:0], 1'b1};
    assign right    = left + 7'd1;
    assign left_ok  = left < count_reg;
    assign right_ok = right < count_reg;

    // carry out one micro-operation per cycle
    always_comb
    begin
        count_next  = count_reg;
        node_next   = node_reg;
        best_next   = best_reg;
        val_next    = val_reg;
        res_next    = res_reg;
        bestv_next  = bestv_reg;
        found_next  = found_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = node_reg[ADDR_W-1:0];
        mem_wdata   = val_reg;
        raddr_a     = node_reg[ADDR_W-1:0];
        raddr_b     = node_reg[ADDR_W-1:0];
        case (cmd)
            CMD_LOAD, CMD_LOAD_INS, CMD_LOAD_FULL, CMD_LOAD_EMPTY:
            begin
                val_next    = in_value;
                res_next    = '0;
                found_next  = 1'b0;
                status_next = ST_OK;
                node_next   = '0;
                if (cmd == CMD_LOAD_INS)
                begin
                    node_next  = count_reg;
                    count_next = count_reg + 7'd1;
                end
                if (cmd == CMD_LOAD_FULL)
                begin
                    status_next = ST_FULL;
                end
                if (cmd == CMD_LOAD_EMPTY)
                begin
                    status_next = ST_EMPTY;
                end
            end
            CMD_UP_RD:
            begin
                raddr_a = parent[ADDR_W-1:0];
            end
            CMD_PLACE:
            begin
                mem_we = 1'b1;
            end
            CMD_UP_MOVE:
            begin
                // move parent down one level
                mem_we    = 1'b1;
                mem_wdata = rdata_a;
                node_next = parent;
            end
            CMD_EX_RD:
            begin
                raddr_a    = '0;
                raddr_b    = ADDR_W'(count_reg - 7'd1);
                count_next = count_reg - 7'd1;
            end
            CMD_EX_MV:
            begin
                res_next  = rdata_a;
                val_next  = rdata_b;
                node_next = '0;
            end
            CMD_DN_RD:
            begin
                raddr_a = left[ADDR_W-1:0];
                raddr_b = right[ADDR_W-1:0];
            end
            CMD_DN_CMP:
            begin
                best_next  = node_reg;
                bestv_next = val_reg;
                if (left_ok && rdata_a > val_reg)
                begin
                    best_next  = left;
                    bestv_next = rdata_a;
                end
                if (right_ok && rdata_b > val_reg && !(left_ok && rdata_a >= rdata_b))
                begin
                    best_next  = right;
                    bestv_next = rdata_b;
                end
            end
            CMD_DN_MOVE:
            begin
                // pull the larger child up
                mem_we    = 1'b1;
                mem_wdata = bestv_reg;
                node_next = best_reg;
            end
            CMD_SR_HIT:
            begin
                found_next = 1'b1;
            end
            CMD_SR_NEXT:
            begin
                node_next = node_reg + 7'd1;
            end
            CMD_SR_MISS:
            begin
                node_next = '0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // write port and two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

    // hold the occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // hold working values
    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        best_reg   <= best_next;
        val_reg    <= val_next;
        res_reg    <= res_next;
        bestv_reg  <= bestv_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    // report conditions to the controller
    assign stat.full       = count_reg >= COUNT_W'(CAPACITY);
    assign stat.empty      = count_reg == '0;
    assign stat.at_root    = node_reg == '0;
    assign stat.up_greater = val_reg > rdata_a;
    assign stat.scan_end   = node_reg >= count_reg;
    assign stat.scan_hit   = rdata_a == val_reg;
    assign stat.at_best    = best_reg == node_reg;

    assign idx_out = found_reg ? node_reg[ADDR_W-1:0] : '0;

    assign out_word.result_value = done ? res_reg : '0;
    assign out_word.found        = done & found_reg;
    assign out_word.found_index  = done ? idx_out : '0;
    assign out_word.status       = done ? status_reg : ST_OK;
    assign out_word.entry_count  = count_reg;

    // assertions
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY)) else $error("count overflow");
    a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == ST_FULL) |-> count_reg == COUNT_W'(CAPACITY))
        else $error("full with room");
    a_found_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found_reg) |-> node_reg < count_reg) else $error("match past end");

endmodule
`default_nettype wire

@@ rtl/core/bmhq_controller.sv @@
`default_nettype none
module bmhq_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [1:0]           action,
    input  wire bmhq_pkg::bmhq_stat_t stat,
    output logic                      busy,
    output logic                      done,
    output bmhq_pkg::bmhq_cmd_t       cmd
);
    import bmhq_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UP_RD  = 4'd1;
    localparam logic [3:0] S_UP_CMP = 4'd2;
    localparam logic [3:0] S_EX_RD  = 4'd3;
    localparam logic [3:0] S_EX_MV  = 4'd4;
    localparam logic [3:0] S_DN_RD  = 4'd5;
    localparam logic [3:0] S_DN_CMP = 4'd6;
    localparam logic [3:0] S_DN_SW  = 4'd7;
    localparam logic [3:0] S_SR_RD  = 4'd8;
    localparam logic [3:0] S_SR_CMP = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       done_reg, done_next;

    // step the sift and scan loops, one level or one entry per pass
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = CMD_NOP;
        case (state_reg)
            S_IDLE:
            begin
                // accept only once the previous result has gone out
                if (start && !done_reg)
                begin
                    case (action)
                        ACT_INSERT:
                        begin
                            if (stat.full)
                            begin
                                cmd        = CMD_LOAD_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                cmd        = CMD_LOAD_INS;
                                state_next = S_UP_RD;
                            end
                        end
                        ACT_EXTRACT:
                        begin
                            if (stat.empty)
                            begin
                                cmd        = CMD_LOAD_EMPTY;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                cmd        = CMD_LOAD;
                                state_next = S_EX_RD;
                            end
                        end
                        ACT_SEARCH:
                        begin
                            cmd        = CMD_LOAD;
                            state_next = S_SR_RD;
                        end
                        default:
                        begin
                            cmd        = CMD_LOAD;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_UP_RD:
            begin
                // root reached: place the value
                if (stat.at_root)
                begin
                    cmd        = CMD_PLACE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_UP_RD;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.up_greater)
                begin
                    cmd        = CMD_UP_MOVE;
                    state_next = S_UP_RD;
                end
                else
                begin
                    cmd        = CMD_PLACE;
                    state_next = S_DONE;
                end
            end
            S_EX_RD:
            begin
                cmd        = CMD_EX_RD;
                state_next = S_EX_MV;
            end
            S_EX_MV:
            begin
                cmd        = CMD_EX_MV;
                state_next = stat.empty ? S_DONE : S_DN_RD;
            end
            S_DN_RD:
            begin
                cmd        = CMD_DN_RD;
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                cmd        = CMD_DN_CMP;
                state_next = S_DN_SW;
            end
            S_DN_SW:
            begin
                if (stat.at_best)
                begin
                    cmd        = CMD_PLACE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_DN_MOVE;
                    state_next = S_DN_RD;
                end
            end
            S_SR_RD:
            begin
                if (stat.scan_end)
                begin
                    cmd        = CMD_SR_MISS;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SR_CMP;
                end
            end
            S_SR_CMP:
            begin
                if (stat.scan_hit)
                begin
                    cmd        = CMD_SR_HIT;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_SR_NEXT;
                    state_next = S_SR_RD;
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;

    // assertions
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done held");
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE) else $error("done not idle");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> state_reg == S_IDLE) else $error("ready while working");

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import bmhq_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      start;
    bmhq_in_t  in_word;
    logic      busy;
    logic      done;
    bmhq_out_t out_word;

    binary_max_heap_queue_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .in_word  (in_word),
        .busy     (busy),
        .done     (done),
        .out_word (out_word)
    );

    // predicted heap contents and occupancy
    logic signed [31:0] heap_vals [CAPACITY];
    int                 heap_size;

    bmhq_in_t  pending_words [$];
    bmhq_out_t expected_words [$];
    int        error_count;
    int        send_idle_pct;
    bit        stim_done;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // apply one word to the heap model and return the predicted result
    function automatic bmhq_out_t heap_apply(bmhq_in_t w);
        bmhq_out_t          r;
        int                 node;
        int                 parent;
        int                 best;
        logic signed [31:0] tmp;
        r = '0;
        if (w.action == ACT_INSERT) begin
            if (heap_size >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                heap_vals[heap_size] = w.value;
                node = heap_size;
                heap_size++;
                while (node > 0) begin
                    parent = (node - 1) / 2;
                    if (!(heap_vals[node] > heap_vals[parent]))
                        break;
                    tmp = heap_vals[node];
                    heap_vals[node] = heap_vals[parent];
                    heap_vals[parent] = tmp;
                    node = parent;
                end
            end
        end else if (w.action == ACT_EXTRACT) begin
            if (heap_size == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.result_value = heap_vals[0];
                heap_vals[0] = heap_vals[heap_size - 1];
                heap_size--;
                node = 0;
                while (node < heap_size) begin
                    best = node;
                    if (2 * node + 1 < heap_size && heap_vals[2 * node + 1] > heap_vals[best])
                        best = 2 * node + 1;
                    if (2 * node + 2 < heap_size && heap_vals[2 * node + 2] > heap_vals[best])
                        best = 2 * node + 2;
                    if (best == node)
                        break;
                    tmp = heap_vals[best];
                    heap_vals[best] = heap_vals[node];
                    heap_vals[node] = tmp;
                    node = best;
                end
            end
        end else if (w.action == ACT_SEARCH) begin
            for (int i = 0; i < heap_size; i++) begin
                if (heap_vals[i] == w.value) begin
                    r.found = 1'b1;
                    r.found_index = i[5:0];
                    break;
                end
            end
        end
        r.entry_count = heap_size[6:0];
        return r;
    endfunction

    function automatic bmhq_in_t make_word(logic [1:0] act, logic [31:0] val);
        bmhq_in_t w;
        w.action = act;
        w.value = val;
        return w;
    endfunction

    // pick a small value, a random word, a large-magnitude word or an extreme so that searches hit and ties occur
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 7) - 4;
            1:       return $urandom();
            2:       return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom())};
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    // driver: hold start until accepted, then advance
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start   <= 1'b0;
            in_word <= '0;
        end else begin
            if (start && !busy) begin
                expected_words.push_back(heap_apply(in_word));
            end
            if (!(start && busy)) begin
                if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    start   <= 1'b1;
                    in_word <= pending_words.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge clk) begin
        bmhq_out_t exp_w;
        if (rst_n && done) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result word %p", out_word);
                error_count++;
            end else begin
                exp_w = expected_words.pop_front();
                if (out_word.result_value !== exp_w.result_value) begin
                    $error("result_value exp %0d got %0d", exp_w.result_value,
                           out_word.result_value);
                    error_count++;
                end
                if (out_word.found !== exp_w.found) begin
                    $error("found exp %0d got %0d", exp_w.found, out_word.found);
                    error_count++;
                end
                if (out_word.found_index !== exp_w.found_index) begin
                    $error("found_index exp %0d got %0d", exp_w.found_index,
                           out_word.found_index);
                    error_count++;
                end
                if (out_word.status !== exp_w.status) begin
                    $error("status exp %0d got %0d", exp_w.status, out_word.status);
                    error_count++;
                end
                if (out_word.entry_count !== exp_w.entry_count) begin
                    $error("entry_count exp %0d got %0d", exp_w.entry_count,
                           out_word.entry_count);
                    error_count++;
                end
            end
        end
    end

    // stimulus: directed cases, then random phases with different idle rates
    initial begin
        int phase_pct [4];
        int fill;
        phase_pct = '{0, 59, 0, 9};
        error_count = 0;
        heap_size = 0;
        send_idle_pct = 0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty extract, search on empty, unused action, extremes and ties
        pending_words.push_back(make_word(ACT_EXTRACT, 32'h0));
        pending_words.push_back(make_word(ACT_SEARCH, 32'h0));
        pending_words.push_back(make_word(2'd3, 32'hffff_ffff));
        pending_words.push_back(make_word(ACT_INSERT, 32'h8000_0000));
        pending_words.push_back(make_word(ACT_INSERT, 32'h7fff_ffff));
        pending_words.push_back(make_word(ACT_INSERT, 32'h0));
        pending_words.push_back(make_word(ACT_INSERT, 32'hffff_ffff));
        pending_words.push_back(make_word(ACT_INSERT, 32'h5));
        pending_words.push_back(make_word(ACT_INSERT, 32'h5));
        pending_words.push_back(make_word(ACT_SEARCH, 32'h5));
        pending_words.push_back(make_word(ACT_SEARCH, 32'h8000_0000));
        pending_words.push_back(make_word(ACT_SEARCH, 32'h1234_5678));
        pending_words.push_back(make_word(2'd3, 32'h0));
        repeat (7) pending_words.push_back(make_word(ACT_EXTRACT, 32'h0));

        // random phases; the even ones start with a fill toward full to reach the full-heap case
        for (int p = 0; p < 4; p++) begin
            wait (pending_words.size() == 0);
            send_idle_pct = phase_pct[p];
            fill = (p % 2 == 0) ? 66 : $urandom_range(10, 40);
            repeat (fill) pending_words.push_back(make_word(ACT_INSERT, pick_value()));
            repeat (30) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: pending_words.push_back(make_word(ACT_INSERT, pick_value()));
                    3, 4, 5: pending_words.push_back(make_word(ACT_EXTRACT, $urandom()));
                    6, 7, 8: pending_words.push_back(make_word(ACT_SEARCH, pick_value()));
                    default: pending_words.push_back(make_word(2'd3, $urandom()));
                endcase
            end
            if (p % 2 == 0)
                repeat (70) pending_words.push_back(make_word(ACT_EXTRACT, $urandom()));
        end
        wait (pending_words.size() == 0);
        @(posedge clk);
        while (start || busy || expected_words.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("binary_max_heap_queue_unit regression: pass");
        else
            $display("binary_max_heap_queue_unit regression: fail");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("binary_max_heap_queue_unit regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
